// File: rtl/iadu_pkg.sv
// ----------------------------------------------------------------------------
// iadu_pkg
// Shared widths, operation codes and sequencer/datapath control types for the
// integer add/sub/mul/div/mod unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iadu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;

  typedef enum logic [3:0] {
    UOP_NONE     = 4'd0,
    UOP_LOAD     = 4'd1,
    UOP_ADD      = 4'd2,
    UOP_SUB      = 4'd3,
    UOP_ABS_A    = 4'd4,
    UOP_ABS_B    = 4'd5,
    UOP_MUL_STEP = 4'd6,
    UOP_DIV_STEP = 4'd7,
    UOP_FIX_QUO  = 4'd8,
    UOP_FIX_REM  = 4'd9
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic neg;
  } ctrl_t;

  typedef struct packed {
    logic a_neg;
    logic b_neg;
  } status_t;

endpackage

// File: rtl/iadu_req_if.sv
// ----------------------------------------------------------------------------
// iadu_req_if
// Request channel: operation code and two signed operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface iadu_req_if import iadu_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [2:0]                   operation;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input operation, input operand_a, input operand_b,
                  output ready);
endinterface

// File: rtl/iadu_rsp_if.sv
// ----------------------------------------------------------------------------
// iadu_rsp_if
// Response channel: result word and divide-by-zero flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface iadu_rsp_if import iadu_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_value;
  logic                         divide_by_zero;

  modport source (output valid, output result_value, output divide_by_zero, input ready);
  modport sink   (input valid, input result_value, input divide_by_zero, output ready);
endinterface

// File: rtl/integer_add_sub_mul_div_mod_unit_core.sv
// ----------------------------------------------------------------------------
// integer_add_sub_mul_div_mod_unit_core
// Result valid once the sequencer registers it on leaving S_DONE: add/sub pass
// through S_ADD or S_SUB, multiply through S_MUL, divide/modulo through
// S_ABS_A, S_ABS_B, S_DIV and S_FIX; a zero divisor or unused code goes
// straight to S_DONE. One item at a time: the sequencer steps the shared adder
// once per operand bit and takes the next item after it has returned to idle.
// Synchronous reset returns the sequencer to idle and clears the valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_add_sub_mul_div_mod_unit_core import iadu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  iadu_req_if.sink    req,
  iadu_rsp_if.source  rsp
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ADD   = 9'b000000010,
    S_SUB   = 9'b000000100,
    S_ABS_A = 9'b000001000,
    S_ABS_B = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_FIX   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [CNT_W-1:0]      cnt;
  logic                  is_mod;
  ctrl_t                 ctrl;
  status_t               status;
  logic [DATA_WIDTH-1:0] result;
  logic                  div_zero;
  logic                  accept;
  logic                  out_load;

  assign req.ready = (state == S_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  assign out_load  = (state == S_DONE) && (!rsp.valid || rsp.ready);

  iadu_datapath u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .operation (req.operation),
    .operand_a (req.operand_a),
    .operand_b (req.operand_b),
    .status    (status),
    .result    (result),
    .div_zero  (div_zero)
  );

  always_comb begin
    ctrl       = '{uop: UOP_NONE, neg: 1'b0};
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          ctrl.uop = UOP_LOAD;
          unique case (req.operation)
            OP_ADD: state_next = S_ADD;
            OP_SUB: state_next = S_SUB;
            OP_MUL: state_next = S_MUL;
            OP_DIV, OP_MOD: state_next = (req.operand_b == '0) ? S_DONE : S_ABS_A;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_ADD: begin
        ctrl.uop   = UOP_ADD;
        state_next = S_DONE;
      end
      S_SUB: begin
        ctrl.uop   = UOP_SUB;
        state_next = S_DONE;
      end
      S_ABS_A: begin
        ctrl.uop   = UOP_ABS_A;
        state_next = S_ABS_B;
      end
      S_ABS_B: begin
        ctrl.uop   = UOP_ABS_B;
        state_next = S_DIV;
      end
      S_MUL: begin
        ctrl.uop = UOP_MUL_STEP;
        if (cnt == LAST_STEP) begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        ctrl.uop = UOP_DIV_STEP;
        if (cnt == LAST_STEP) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        // remainder follows the dividend sign, quotient the sign difference
        ctrl.uop   = is_mod ? UOP_FIX_REM : UOP_FIX_QUO;
        ctrl.neg   = is_mod ? status.a_neg : (status.a_neg ^ status.b_neg);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (accept) begin
        cnt <= '0;
      end else if (state == S_MUL || state == S_DIV) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_mod <= (req.operation == OP_MOD);
    end
    if (out_load) begin
      rsp.result_value   <= result;
      rsp.divide_by_zero <= div_zero;
    end
  end

endmodule

// File: rtl/iadu_adder.sv
// ----------------------------------------------------------------------------
// iadu_adder
// Shared add/subtract unit, one bit wider than the word plus a sign bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iadu_adder import iadu_pkg::*; (
  input  logic [DATA_WIDTH:0]   x,
  input  logic [DATA_WIDTH:0]   y,
  input  logic                  sub,
  output logic [DATA_WIDTH+1:0] sum
);

  logic [DATA_WIDTH+1:0] y_ext;

  assign y_ext = {1'b0, y} ^ {(DATA_WIDTH + 2){sub}};
  assign sum   = {1'b0, x} + y_ext + (DATA_WIDTH + 2)'(sub);

endmodule

// File: rtl/iadu_datapath.sv
// ----------------------------------------------------------------------------
// iadu_datapath
// Operand, accumulator and quotient registers around the shared adder.
// Multiply is shift-add, divide is restoring on magnitudes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iadu_datapath import iadu_pkg::*; (
  input  logic                         clk,
  input  ctrl_t                        ctrl,
  input  logic [2:0]                   operation,
  input  logic signed [DATA_WIDTH-1:0] operand_a,
  input  logic signed [DATA_WIDTH-1:0] operand_b,
  output status_t                      status,
  output logic [DATA_WIDTH-1:0]        result,
  output logic                         div_zero
);

  logic [DATA_WIDTH-1:0] a_reg;
  logic [DATA_WIDTH-1:0] b_reg;
  logic [DATA_WIDTH:0]   acc;
  logic                  a_neg;
  logic                  b_neg;
  logic                  dz;

  logic [DATA_WIDTH:0]   add_x;
  logic [DATA_WIDTH:0]   add_y;
  logic                  add_sub;
  logic [DATA_WIDTH+1:0] add_sum;
  logic                  b_is_zero;
  logic                  is_divmod;

  iadu_adder u_adder (
    .x   (add_x),
    .y   (add_y),
    .sub (add_sub),
    .sum (add_sum)
  );

  assign b_is_zero = (operand_b == '0);
  assign is_divmod = (operation == OP_DIV) || (operation == OP_MOD);

  always_comb begin
    add_x   = acc;
    add_y   = {1'b0, a_reg};
    add_sub = 1'b0;
    unique case (ctrl.uop)
      UOP_ADD: begin
        add_x = {1'b0, a_reg};
        add_y = {1'b0, b_reg};
      end
      UOP_SUB: begin
        add_x   = {1'b0, a_reg};
        add_y   = {1'b0, b_reg};
        add_sub = 1'b1;
      end
      UOP_ABS_A: begin
        add_x   = '0;
        add_sub = 1'b1;
      end
      UOP_ABS_B: begin
        add_x   = '0;
        add_y   = {1'b0, b_reg};
        add_sub = 1'b1;
      end
      UOP_MUL_STEP: begin
        add_x = acc;
      end
      UOP_DIV_STEP: begin
        add_x   = {acc[DATA_WIDTH-1:0], a_reg[DATA_WIDTH-1]};
        add_y   = {1'b0, b_reg};
        add_sub = 1'b1;
      end
      UOP_FIX_QUO: begin
        add_x   = '0;
        add_sub = 1'b1;
      end
      UOP_FIX_REM: begin
        add_x   = '0;
        add_y   = {1'b0, acc[DATA_WIDTH-1:0]};
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.uop)
      UOP_LOAD: begin
        a_reg <= operand_a;
        b_reg <= operand_b;
        a_neg <= operand_a[DATA_WIDTH-1];
        b_neg <= operand_b[DATA_WIDTH-1];
        dz    <= is_divmod && b_is_zero;
        if (operation == OP_DIV && b_is_zero) begin
          acc <= {1'b0, {DATA_WIDTH{1'b1}}};
        end else if (operation == OP_MOD && b_is_zero) begin
          acc <= {1'b0, operand_a};
        end else begin
          acc <= '0;
        end
      end
      UOP_ADD, UOP_SUB: begin
        acc <= {1'b0, add_sum[DATA_WIDTH-1:0]};
      end
      UOP_ABS_A: begin
        if (a_neg) begin
          a_reg <= add_sum[DATA_WIDTH-1:0];
        end
      end
      UOP_ABS_B: begin
        if (b_neg) begin
          b_reg <= add_sum[DATA_WIDTH-1:0];
        end
      end
      UOP_MUL_STEP: begin
        if (b_reg[0]) begin
          acc <= {1'b0, add_sum[DATA_WIDTH-1:0]};
        end
        a_reg <= {a_reg[DATA_WIDTH-2:0], 1'b0};
        b_reg <= {1'b0, b_reg[DATA_WIDTH-1:1]};
      end
      UOP_DIV_STEP: begin
        // restore on borrow; quotient bits shift in behind the dividend
        if (add_sum[DATA_WIDTH+1]) begin
          acc <= add_x;
        end else begin
          acc <= add_sum[DATA_WIDTH:0];
        end
        a_reg <= {a_reg[DATA_WIDTH-2:0], ~add_sum[DATA_WIDTH+1]};
      end
      UOP_FIX_QUO: begin
        acc <= {1'b0, ctrl.neg ? add_sum[DATA_WIDTH-1:0] : a_reg};
      end
      UOP_FIX_REM: begin
        acc <= {1'b0, ctrl.neg ? add_sum[DATA_WIDTH-1:0] : acc[DATA_WIDTH-1:0]};
      end
      default: begin
      end
    endcase
  end

  assign status.a_neg = a_neg;
  assign status.b_neg = b_neg;
  assign result       = acc[DATA_WIDTH-1:0];
  assign div_zero     = dz;

endmodule
